// ===== sv/rmsp_pkg.sv =====
// Shared types, widths and register codes for the RMSprop weight update block.
`default_nettype none
package rmsp_pkg;

    localparam int IDX_W      = 12;   // weight index field
    localparam int VAL_W      = 32;   // Q8.24 weight and gradient
    localparam int DECAY_W    = 16;
    localparam int RATE_W     = 24;
    localparam int EPS_W      = 16;
    localparam int MS_W       = 48;   // Q16.32 mean square
    localparam int G2_W       = 48;
    localparam int MIX_W      = 65;   // (1-decay) * g^2
    localparam int ROOT_W     = 32;   // Q8.24 root
    localparam int SQ_IN_W    = 64;
    localparam int SQ_REM_W   = 34;
    localparam int DEN_W      = 33;
    localparam int NUM_W      = 56;   // rate * |g|
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64881;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd167772;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd168;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY = 2'd0,
        CFG_RATE  = 2'd1,
        CFG_EPS   = 2'd2
    } rmsp_cfg_e;

    // Sideband carried through the root pipeline
    typedef struct packed {
        logic signed [VAL_W-1:0] weight;
        logic                    neg;
        logic                    sat;
        logic [NUM_W-1:0]        num;
    } rmsp_sq_side_t;

    // Sideband carried through the divider pipeline
    typedef struct packed {
        logic signed [VAL_W-1:0] weight;
        logic                    neg;
        logic                    sat;
    } rmsp_dv_side_t;

endpackage
`default_nettype wire

// ===== sv/rmsprop_weight_update.sv =====
// Top level of the RMSprop weight update: mean-square store, update pipeline and output buffer.
`default_nettype none
// One beat in carries a weight index, the present weight and its gradient (Q8.24); one beat out
// carries the updated weight and a clip flag. The block takes one beat per cycle while s_ready is
// high and returns results in order through five front stages (gradient square, mix products,
// store read and mean-square write-back), 32 root stages, 56 divider stages, one output stage and
// the output register. The mean square lives in a one-port-write RAM; consecutive beats on the
// same index are served by forwarding the value just written, so any index pattern runs at full
// rate. After reset a clearing pass zeroes all WEIGHT_COUNT entries of the store, one entry a
// cycle; s_ready stays low during it, configuration writes are taken. A two-entry output buffer
// keeps m_ready out of the input path. Write registers only when idle.
module rmsprop_weight_update
    import rmsp_pkg::*;
#(
    parameter int WEIGHT_COUNT = 4096
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    // input beats
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [IDX_W-1:0]        s_weight_index,
    input  wire logic signed [VAL_W-1:0] s_current_weight,
    input  wire logic signed [VAL_W-1:0] s_gradient,
    // result beats
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [VAL_W-1:0]      m_new_weight,
    output logic                         m_saturated
);

    localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
    localparam logic [MS_W-1:0] MS_MAX = '1;

    // Configuration registers
    logic [DECAY_W-1:0] decay_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [EPS_W-1:0]   eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= DECAY_RESET;
            rate_reg  <= RATE_RESET;
            eps_reg   <= EPS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DECAY: decay_reg <= cfg_data[DECAY_W-1:0];
                CFG_RATE:  rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_EPS:   eps_reg   <= cfg_data[EPS_W-1:0];
                default:   ;  // unknown index: drop the write
            endcase
        end
    end

    // Pipeline advance: hold everything while the output skid entry is occupied
    logic skid_valid_reg;
    logic en;
    logic clear_reg;
    logic accept;

    assign en      = !skid_valid_reg;
    assign s_ready = en && !clear_reg;
    assign accept  = s_valid && s_ready;

    // Clearing pass over the store after reset
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clear_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(WEIGHT_COUNT - 1)) begin
                clear_reg <= 1'b0;
            end
        end
    end

    // ---------------- Stage A: captured beat ----------------
    logic                    a_valid;
    logic [IDX_W-1:0]        a_idx;
    logic signed [VAL_W-1:0] a_w;
    logic                    a_neg;
    logic [VAL_W-1:0]        a_mag;
    logic [VAL_W-1:0]        g_u;

    assign g_u = s_gradient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid <= 1'b0;
        end else if (en) begin
            a_valid <= accept;
        end
        if (en) begin
            a_idx <= s_weight_index;
            a_w   <= s_current_weight;
            a_neg <= s_gradient[VAL_W-1];
            a_mag <= s_gradient[VAL_W-1] ? (~g_u + 1'b1) : g_u;
        end
    end

    // Reduce the index modulo the store depth, upper half of the steps here
    logic [IDX_W-1:0]   idx_half;
    logic [2*VAL_W-1:0] g_sq;

    always_comb begin
        logic [29:0] lim;
        idx_half = a_idx;
        for (int k = 11; k >= 6; k--) begin
            lim = 30'(WEIGHT_COUNT) << k;
            if (30'(idx_half) >= lim) begin
                idx_half = IDX_W'(30'(idx_half) - lim);
            end
        end
    end

    assign g_sq = a_mag * a_mag;

    // ---------------- Stage B: gradient square ----------------
    logic                    b_valid;
    logic [IDX_W-1:0]        b_idx;
    logic signed [VAL_W-1:0] b_w;
    logic                    b_neg;
    logic [VAL_W-1:0]        b_mag;
    logic [G2_W-1:0]         b_g2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid <= 1'b0;
        end else if (en) begin
            b_valid <= a_valid;
        end
        if (en) begin
            b_idx <= idx_half;
            b_w   <= a_w;
            b_neg <= a_neg;
            b_mag <= a_mag;
            b_g2  <= g_sq[2*VAL_W-1:16];
        end
    end

    logic [IDX_W-1:0] idx_full;
    logic [16:0]      one_minus_decay;
    logic [MIX_W-1:0] mix_g;
    logic [NUM_W-1:0] num_next;

    always_comb begin
        logic [29:0] lim;
        idx_full = b_idx;
        for (int k = 5; k >= 0; k--) begin
            lim = 30'(WEIGHT_COUNT) << k;
            if (30'(idx_full) >= lim) begin
                idx_full = IDX_W'(30'(idx_full) - lim);
            end
        end
    end

    assign one_minus_decay = 17'h10000 - {1'b0, decay_reg};
    assign mix_g           = MIX_W'(one_minus_decay) * MIX_W'(b_g2);
    assign num_next        = NUM_W'(rate_reg) * NUM_W'(b_mag);

    // ---------------- Stage C: store read issued ----------------
    logic                    c_valid;
    logic [AW-1:0]           c_idx;
    logic signed [VAL_W-1:0] c_w;
    logic                    c_neg;
    logic [MIX_W-1:0]        c_mix;
    logic [NUM_W-1:0]        c_num;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid <= 1'b0;
        end else if (en) begin
            c_valid <= b_valid;
        end
        if (en) begin
            c_idx <= AW'(idx_full);
            c_w   <= b_w;
            c_neg <= b_neg;
            c_mix <= mix_g;
            c_num <= num_next;
        end
    end

    // ---------------- Stage D: read data back, mix, write back ----------------
    logic                    d_valid;
    logic [AW-1:0]           d_idx;
    logic signed [VAL_W-1:0] d_w;
    logic                    d_neg;
    logic [MIX_W-1:0]        d_mix;
    logic [NUM_W-1:0]        d_num;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid <= 1'b0;
        end else if (en) begin
            d_valid <= c_valid;
        end
        if (en) begin
            d_idx <= c_idx;
            d_w   <= c_w;
            d_neg <= c_neg;
            d_mix <= c_mix;
            d_num <= c_num;
        end
    end

    logic                    e_valid;
    logic [AW-1:0]           e_idx;
    logic [MS_W-1:0]         e_ms;
    logic signed [VAL_W-1:0] e_w;
    logic                    e_neg;
    logic                    e_sat;
    logic [NUM_W-1:0]        e_num;

    logic [MS_W-1:0]  ram_rdata;
    logic [MS_W-1:0]  ms_sel;
    logic [63:0]      decay_ms;
    logic [65:0]      ms_sum;
    logic [49:0]      ms_shift;
    logic [MS_W-1:0]  ms_new;
    logic             ms_clip;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [MS_W-1:0]  ram_wdata;

    // The entry written at the edge this read completed is still in stage E: forward it
    assign ms_sel   = (e_valid && (e_idx == d_idx)) ? e_ms : ram_rdata;
    assign decay_ms = 64'(decay_reg) * 64'(ms_sel);
    assign ms_sum   = 66'(decay_ms) + 66'(d_mix) + 66'(32768);
    assign ms_shift = ms_sum[65:16];
    assign ms_clip  = (ms_shift > 50'(MS_MAX));
    assign ms_new   = ms_clip ? MS_MAX : ms_shift[MS_W-1:0];

    assign ram_we    = clear_reg || (en && d_valid);
    assign ram_waddr = clear_reg ? clr_cnt_reg : d_idx;
    assign ram_wdata = clear_reg ? '0 : ms_new;

    rmsp_ram #(
        .WIDTH (MS_W),
        .DEPTH (WEIGHT_COUNT)
    ) u_ms_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (en),
        .rd_addr (c_idx),
        .rd_data (ram_rdata)
    );

    // ---------------- Stage E: new mean square ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid <= 1'b0;
        end else if (en) begin
            e_valid <= d_valid;
        end
        if (en) begin
            e_idx <= d_idx;
            e_ms  <= ms_new;
            e_w   <= d_w;
            e_neg <= d_neg;
            e_sat <= ms_clip;
            e_num <= d_num;
        end
    end

    // ---------------- Root of the mean square (Q8.24) ----------------
    rmsp_sq_side_t sq_side_in;
    rmsp_sq_side_t sq_side_out;
    logic          sq_valid;
    logic [ROOT_W-1:0] sq_root;

    assign sq_side_in.weight = e_w;
    assign sq_side_in.neg    = e_neg;
    assign sq_side_in.sat    = e_sat;
    assign sq_side_in.num    = e_num;

    rmsp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid),
        .in_x      ({e_ms, 16'h0000}),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_out)
    );

    // ---------------- Step = rate*|g| / (root + epsilon) ----------------
    logic [EPS_W-1:0] eps_eff;
    logic [DEN_W-1:0] den;
    rmsp_dv_side_t    dv_side_in;
    rmsp_dv_side_t    dv_side_out;
    logic             dv_valid;
    logic [NUM_W-1:0] dv_quot;

    // A zero epsilon acts as one so the divisor never vanishes
    assign eps_eff = (eps_reg == '0) ? EPS_W'(1) : eps_reg;
    assign den     = DEN_W'(sq_root) + DEN_W'(eps_eff);

    assign dv_side_in.weight = sq_side_out.weight;
    assign dv_side_in.neg    = sq_side_out.neg;
    assign dv_side_in.sat    = sq_side_out.sat;

    rmsp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_side_out.num),
        .in_den    (den),
        .in_side   (dv_side_in),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side_out)
    );

    // ---------------- Stage F: apply the step and clip ----------------
    logic signed [NUM_W+1:0] w_ext;
    logic signed [NUM_W+1:0] q_ext;
    logic signed [NUM_W+1:0] nw_wide;
    logic signed [VAL_W-1:0] nw_clip;
    logic                    nw_sat;

    assign w_ext   = (NUM_W+2)'(dv_side_out.weight);
    assign q_ext   = $signed({2'b00, dv_quot});
    assign nw_wide = dv_side_out.neg ? (w_ext + q_ext) : (w_ext - q_ext);

    always_comb begin
        nw_sat  = 1'b0;
        nw_clip = nw_wide[VAL_W-1:0];
        if (nw_wide > (NUM_W+2)'(32'sh7FFFFFFF)) begin
            nw_clip = 32'sh7FFFFFFF;
            nw_sat  = 1'b1;
        end else if (nw_wide < -((NUM_W+2)'(64'sh80000000))) begin
            nw_clip = 32'sh80000000;
            nw_sat  = 1'b1;
        end
    end

    logic                    f_valid;
    logic signed [VAL_W-1:0] f_nw;
    logic                    f_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid <= 1'b0;
        end else if (en) begin
            f_valid <= dv_valid;
        end
        if (en) begin
            f_nw  <= nw_clip;
            f_sat <= nw_sat || dv_side_out.sat;
        end
    end

    // ---------------- Output register and skid entry ----------------
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_nw_reg;
    logic                    out_sat_reg;
    logic signed [VAL_W-1:0] skid_nw_reg;
    logic                    skid_sat_reg;
    logic                    push;
    logic                    out_free;

    assign push     = en && f_valid;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            // Drain the skid entry first; the pipeline is held while it is full
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
        if (out_free) begin
            out_nw_reg  <= skid_valid_reg ? skid_nw_reg  : f_nw;
            out_sat_reg <= skid_valid_reg ? skid_sat_reg : f_sat;
        end else if (push) begin
            skid_nw_reg  <= f_nw;
            skid_sat_reg <= f_sat;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_new_weight = out_nw_reg;
    assign m_saturated  = out_sat_reg;

    // ---------------- Assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while output register is empty");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_reg |=> !clear_reg)
        else $error("clearing pass restarted without reset");

    a_no_write_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && !clear_reg) |-> !ram_we)
        else $error("store written while the pipeline is held");

endmodule
`default_nettype wire

// ===== sv/rmsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rmsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/rmsp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rmsp_sqrt
    import rmsp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [SQ_IN_W-1:0]  in_x,
    input  wire rmsp_sq_side_t       in_side,
    output logic                     out_valid,
    output logic [ROOT_W-1:0]        out_root,
    output rmsp_sq_side_t            out_side
);

    localparam int STAGES = ROOT_W;

    logic                vld  [0:STAGES];
    logic [SQ_IN_W-1:0]  x    [0:STAGES];
    logic [SQ_REM_W-1:0] rem  [0:STAGES];
    logic [ROOT_W-1:0]   res  [0:STAGES];
    rmsp_sq_side_t       side [0:STAGES];

    assign vld[0]  = in_valid;
    assign x[0]    = in_x;
    assign rem[0]  = '0;
    assign res[0]  = '0;
    assign side[0] = in_side;

    for (genvar i = 1; i <= STAGES; i++) begin : g_stage
        logic [SQ_REM_W+1:0] rem_t;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W-1:0] rem_n;
        logic [ROOT_W-1:0]   res_n;

        always_comb begin
            rem_t = {rem[i-1], x[i-1][SQ_IN_W-1 -: 2]};
            trial = (SQ_REM_W+2)'({res[i-1], 2'b01});
            if (rem_t >= trial) begin
                rem_n = SQ_REM_W'(rem_t - trial);
                res_n = {res[i-1][ROOT_W-2:0], 1'b1};
            end else begin
                rem_n = SQ_REM_W'(rem_t);
                res_n = {res[i-1][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld[i] <= 1'b0;
            end else if (en) begin
                vld[i] <= vld[i-1];
            end
            if (en) begin
                x[i]    <= {x[i-1][SQ_IN_W-3:0], 2'b00};
                rem[i]  <= rem_n;
                res[i]  <= res_n;
                side[i] <= side[i-1];
            end
        end
    end

    assign out_valid = vld[STAGES];
    assign out_root  = res[STAGES];
    assign out_side  = side[STAGES];

endmodule
`default_nettype wire

// ===== sv/rmsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rmsp_div
    import rmsp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire rmsp_dv_side_t     in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quot,
    output rmsp_dv_side_t          out_side
);

    localparam int STAGES = NUM_W;

    logic             vld  [0:STAGES];
    logic [NUM_W-1:0] nq   [0:STAGES];
    logic [DEN_W-1:0] rem  [0:STAGES];
    logic [DEN_W-1:0] den  [0:STAGES];
    rmsp_dv_side_t    side [0:STAGES];

    assign vld[0]  = in_valid;
    assign nq[0]   = in_num;
    assign rem[0]  = '0;
    assign den[0]  = in_den;
    assign side[0] = in_side;

    for (genvar i = 1; i <= STAGES; i++) begin : g_stage
        logic [DEN_W:0]   rem_t;
        logic [DEN_W-1:0] rem_n;
        logic             qbit;

        always_comb begin
            rem_t = {rem[i-1], nq[i-1][NUM_W-1]};
            if (rem_t >= {1'b0, den[i-1]}) begin
                rem_n = DEN_W'(rem_t - {1'b0, den[i-1]});
                qbit  = 1'b1;
            end else begin
                rem_n = rem_t[DEN_W-1:0];
                qbit  = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld[i] <= 1'b0;
            end else if (en) begin
                vld[i] <= vld[i-1];
            end
            if (en) begin
                nq[i]   <= {nq[i-1][NUM_W-2:0], qbit};
                rem[i]  <= rem_n;
                den[i]  <= den[i-1];
                side[i] <= side[i-1];
            end
        end
    end

    assign out_valid = vld[STAGES];
    assign out_quot  = nq[STAGES];
    assign out_side  = side[STAGES];

endmodule
`default_nettype wire
